FILE: hw/rtl/kpdc_pkg.sv
package kpdc_pkg;

    // fixed field widths
    localparam int KEY_W   = 3;
    localparam int CFG_W   = 16;
    localparam int MASK_W  = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // default sizing
    localparam int NUM_KEYS_DEF    = 5;
    localparam int COUNT_WIDTH_DEF = 16;

    // register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd500;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd100;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_EDGE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_CLICKED = 2'd1,
        ST_HOLD    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_TIMEOUT  = 2'd0,
        REG_DEBOUNCE = 2'd1,
        REG_HOLD     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] timeout_ticks;
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        t_opcode          opcode;
        logic [KEY_W-1:0] key_index;
        logic             pin_level;
    } t_item;

    typedef struct packed {
        logic [KEY_W-1:0]  event_key;
        t_status           event_status;
        logic [MASK_W-1:0] timeout_mask;
        logic              motor_start;
    } t_result;

endpackage

FILE: hw/rtl/kpdc_cfg.sv
module kpdc_cfg
    import kpdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks  <= TIMEOUT_RST;
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.hold_ticks     <= HOLD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TIMEOUT:  r_cfg.timeout_ticks  <= pwdata[CFG_W-1:0];
                REG_DEBOUNCE: r_cfg.debounce_ticks <= pwdata[CFG_W-1:0];
                REG_HOLD:     r_cfg.hold_ticks     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TIMEOUT:  prdata = PDATA_W'(r_cfg.timeout_ticks);
            REG_DEBOUNCE: prdata = PDATA_W'(r_cfg.debounce_ticks);
            REG_HOLD:     prdata = PDATA_W'(r_cfg.hold_ticks);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/kpdc_core.sv
module kpdc_core
    import kpdc_pkg::*;
#(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [NUM_KEYS-1:0]    r_running;
    logic [COUNT_WIDTH-1:0] r_count  [NUM_KEYS];
    t_status                r_status [NUM_KEYS];

    logic [NUM_KEYS-1:0]    n_running;
    logic [COUNT_WIDTH-1:0] n_count  [NUM_KEYS];
    t_status                n_status [NUM_KEYS];

    logic [COUNT_WIDTH-1:0] tick_inc [NUM_KEYS];
    logic [NUM_KEYS-1:0]    expire;
    logic [MASK_W-1:0]      mask;
    t_status                ev_status;
    logic                   motor;

    // saturating increment and timeout check per key
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            tick_inc[k] = (r_count[k] != COUNT_MAX) ? r_count[k] + 1'b1 : r_count[k];
            expire[k]   = r_running[k] && (i_item.opcode == OP_TICK) &&
                          (CMP_W'(tick_inc[k]) >= CMP_W'(i_cfg.timeout_ticks));
        end
    end

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        n_status  = r_status;
        ev_status = ST_NORMAL;
        motor     = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (i_item.opcode == OP_TICK) begin
                if (expire[k]) begin
                    n_running[k] = 1'b0;
                    n_count[k]   = '0;
                    n_status[k]  = ST_NORMAL;
                end else if (r_running[k]) begin
                    n_count[k] = tick_inc[k];
                end
            end else if (32'(i_item.key_index) == k) begin
                if (r_running[k]) begin
                    // shake wins over hold
                    if (CMP_W'(r_count[k]) < CMP_W'(i_cfg.debounce_ticks)) begin
                        n_status[k] = ST_NORMAL;
                    end else if (CMP_W'(r_count[k]) > CMP_W'(i_cfg.hold_ticks)) begin
                        n_status[k] = ST_HOLD;
                        motor       = 1'b1;
                    end else begin
                        n_status[k] = ST_CLICKED;
                    end
                    n_running[k] = 1'b0;
                    n_count[k]   = '0;
                end else if (!i_item.pin_level) begin
                    n_running[k] = 1'b1;
                    n_count[k]   = '0;
                end
                ev_status = n_status[k];
            end
        end
    end

    // only the first keys have a timeout bit
    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < NUM_KEYS) begin : g_on
            assign mask[g] = expire[g];
        end else begin : g_off
            assign mask[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_count[k]  <= '0;
                r_status[k] <= ST_NORMAL;
            end
        end else if (i_fire) begin
            r_running <= n_running;
            r_count   <= n_count;
            r_status  <= n_status;
        end
    end

    always_comb begin
        o_result.event_key    = (i_item.opcode == OP_EDGE) ? i_item.key_index : '0;
        o_result.event_status = ev_status;
        o_result.timeout_mask = mask;
        o_result.motor_start  = motor;
    end

endmodule

FILE: hw/rtl/key_press_duration_classifier.sv
// an accepted item is captured in the input register, classified by the core logic and then
// captured in the result register; a stall on the result channel holds it where it is
// throughput: one item per cycle while the result channel is not stalled; the per-key update
// of running flag, count and status is combinational between the two registers
// reset: synchronous, active low; all keys idle with count zero and status normal,
// registers back to timeout 500, debounce 50, hold 100 ticks, both pipeline stages empty
module key_press_duration_classifier
    import kpdc_pkg::*;
#(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic               i_pin_level,
    // result item channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [KEY_W-1:0]   o_event_key,
    output logic [1:0]         o_event_status,
    output logic [MASK_W-1:0]  o_timeout_mask,
    output logic               o_motor_start,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_result core_res;

    // input register stage
    logic    r_in_valid;
    t_item   r_in_item;

    // result register stage
    logic    r_out_valid;
    t_result r_out_res;

    logic    out_free;
    logic    fire;

    kpdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // result register can take a new item when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    // the item in the input register moves on and updates key state
    assign fire       = r_in_valid && out_free;
    // input register holds only while its item is blocked
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item.opcode    <= t_opcode'(i_opcode);
            r_in_item.key_index <= i_key_index;
            r_in_item.pin_level <= i_pin_level;
        end
    end

    kpdc_core #(
        .NUM_KEYS    (NUM_KEYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_key    = r_out_res.event_key;
    assign o_event_status = r_out_res.event_status;
    assign o_timeout_mask = r_out_res.timeout_mask;
    assign o_motor_start  = r_out_res.motor_start;

endmodule
